>>> hw/rtl/bfg_pkg.sv
package bfg_pkg;

    localparam int ADC_W   = 12;
    localparam int SUM_W   = 16;
    localparam int MV_W    = 15;
    localparam int PCT_W   = 7;
    localparam int RATIO_W = 12;
    localparam int CFG_W   = 15;
    localparam int IDX_W   = 2;
    localparam int DIV_W   = 28;
    localparam int QUO_W   = 16;

    localparam logic [IDX_W-1:0] CFG_RATIO    = 2'd0;
    localparam logic [IDX_W-1:0] CFG_FULL_MV  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_EMPTY_MV = 2'd2;

    localparam logic [RATIO_W-1:0] RATIO_RST    = 12'd512;
    localparam logic [MV_W-1:0]    FULL_MV_RST  = 15'd4200;
    localparam logic [MV_W-1:0]    EMPTY_MV_RST = 15'd3000;

    localparam logic [MV_W-1:0]  MV_SAT  = 15'h7fff;
    localparam logic [11:0]      K_3300  = 12'd3300;
    localparam logic [12:0]      K_4095  = 13'd4095;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic [MV_W-1:0]    full_mv;
        logic [MV_W-1:0]    empty_mv;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor_sh;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quotient;
    } t_div_rsp;

endpackage

>>> hw/rtl/bfg_fifo.sv
module bfg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> hw/rtl/bfg_front.sv
module bfg_front #(
    parameter int WINDOW_LEN = 10,
    parameter int CNT_W      = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [bfg_pkg::ADC_W-1:0]   i_sample,
    input  logic                        i_q_full,
    output logic                        o_q_push,
    output logic [bfg_pkg::SUM_W-1:0]   o_q_sum,
    output logic [CNT_W-1:0]            o_q_count
);

    import bfg_pkg::*;

    localparam int PW = $clog2(WINDOW_LEN);

    logic [ADC_W-1:0] r_ring [WINDOW_LEN];
    logic [PW-1:0]    r_pos, n_pos;
    logic [CNT_W-1:0] r_count, n_count;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic             accept;
    logic             window_full;

    assign accept      = i_push && !i_q_full;
    assign window_full = (r_count >= CNT_W'(WINDOW_LEN));

    always_comb begin
        n_pos   = (r_pos == PW'(WINDOW_LEN - 1)) ? '0 : r_pos + 1'b1;
        n_count = window_full ? r_count : r_count + 1'b1;
        if (window_full) begin
            n_sum = r_sum - SUM_W'(r_ring[r_pos]) + SUM_W'(i_sample);
        end else begin
            n_sum = r_sum + SUM_W'(i_sample);
        end
    end

    assign o_q_push  = accept;
    assign o_q_sum   = n_sum;
    assign o_q_count = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_count <= '0;
            r_sum   <= '0;
        end else if (accept) begin
            r_pos   <= n_pos;
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ring[r_pos] <= i_sample;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(WINDOW_LEN))
        else $error("sample count past window length");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && window_full) |=> (r_count == $past(r_count)))
        else $error("sample count moved with a full window");

endmodule

>>> hw/rtl/bfg_div.sv
module bfg_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bfg_pkg::t_div_req   i_req,
    output bfg_pkg::t_div_rsp   o_rsp
);

    import bfg_pkg::*;

    localparam int IW = $clog2(QUO_W);

    logic             r_busy;
    logic             r_done;
    logic [IW-1:0]    r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_sd;
    logic [QUO_W-1:0] r_q;
    logic             fits;

    assign fits = (r_rem >= r_sd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == IW'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend;
            r_sd  <= i_req.divisor_sh;
            r_q   <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - r_sd;
            end
            r_q  <= {r_q[QUO_W-2:0], fits};
            r_sd <= r_sd >> 1;
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divide started while busy");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_busy) && !r_busy))
        else $error("divide done without a run");

endmodule

>>> hw/rtl/bfg_back.sv
module bfg_back #(
    parameter int CNT_W = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bfg_pkg::t_cfg                     i_cfg,
    input  logic                              i_q_empty,
    input  logic [bfg_pkg::SUM_W-1:0]         i_q_sum,
    input  logic [CNT_W-1:0]                  i_q_count,
    output logic                              o_q_pop,
    output bfg_pkg::t_div_req                 o_div_req,
    input  bfg_pkg::t_div_rsp                 i_div_rsp,
    input  logic                              i_out_full,
    output logic                              o_out_push,
    output logic [bfg_pkg::MV_W-1:0]          o_voltage_mv,
    output logic [bfg_pkg::PCT_W-1:0]         o_percent,
    output logic                              o_charging
);

    import bfg_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIV1   = 3'd1;
    localparam logic [2:0] S_MUL1   = 3'd2;
    localparam logic [2:0] S_MUL2   = 3'd3;
    localparam logic [2:0] S_REC1   = 3'd4;
    localparam logic [2:0] S_REC2   = 3'd5;
    localparam logic [2:0] S_REC3   = 3'd6;
    localparam logic [2:0] S_PCT    = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [ADC_W-1:0] r_mean;
    logic [23:0]      r_p1;
    logic [35:0]      r_p2;
    logic [16:0]      r_q0;
    logic [12:0]      r_rem;
    logic [MV_W-1:0]  r_v;
    logic [MV_W-1:0]  r_prev;
    logic [DIV_W-1:0] y;
    logic [28:0]      qsum;
    logic [28:0]      rem_full;
    logic [16:0]      qf;
    logic             start1;
    logic [PCT_W-1:0] pct;
    logic [MV_W-1:0]  d;
    logic [8:0]       dn;
    logic [19:0]      prod;

    assign start1 = (r_state == S_IDLE) && !i_q_empty && !i_out_full;
    assign y      = r_p2[35:8];

    // divide by 4095 as a shift-add estimate, low by at most one, then one correction
    assign qsum     = {1'b0, y} + 29'(y[DIV_W-1:12]) + 29'(y[DIV_W-1:24]);
    assign rem_full = {1'b0, y} - {r_q0, 12'b0} + 29'(r_q0);
    assign qf       = r_q0 + 17'(r_rem >= K_4095);

    assign o_q_pop              = start1;
    assign o_div_req.start      = start1;
    assign o_div_req.dividend   = DIV_W'(i_q_sum);
    assign o_div_req.divisor_sh = DIV_W'({i_q_count, 15'b0});

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (start1) n_state = S_DIV1;
            S_DIV1:   if (i_div_rsp.done) n_state = S_MUL1;
            S_MUL1:   n_state = S_MUL2;
            S_MUL2:   n_state = S_REC1;
            S_REC1:   n_state = S_REC2;
            S_REC2:   n_state = S_REC3;
            S_REC3:   n_state = S_PCT;
            S_PCT:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // six-segment curve, small constant divides by reciprocal multiply
    always_comb begin
        d    = '0;
        dn   = '0;
        prod = '0;
        pct  = '0;
        if (r_v >= i_cfg.full_mv) begin
            pct = 7'd100;
        end else if (r_v <= i_cfg.empty_mv) begin
            pct = 7'd0;
        end else if (r_v >= 15'd4100) begin
            d = r_v - 15'd4100;
            if (d >= 15'd100) begin
                pct = 7'd100;
            end else begin
                dn   = d[8:0];
                prod = 20'(dn) * 20'd205;
                pct  = 7'd90 + 7'(prod[19:11]);
            end
        end else if (r_v >= 15'd3900) begin
            d    = r_v - 15'd3900;
            dn   = d[8:0];
            prod = 20'(dn) * 20'd205;
            pct  = 7'd70 + 7'(prod[19:11]);
        end else if (r_v >= 15'd3700) begin
            d    = r_v - 15'd3700;
            dn   = d[8:0];
            prod = (20'(dn) * 20'd3) * 20'd205;
            pct  = 7'd40 + 7'(prod[19:12]);
        end else if (r_v >= 15'd3500) begin
            d    = r_v - 15'd3500;
            dn   = d[8:0];
            prod = 20'(dn) * 20'd205;
            pct  = 7'd20 + 7'(prod[19:11]);
        end else if (r_v >= 15'd3300) begin
            d    = r_v - 15'd3300;
            dn   = d[8:0];
            prod = (20'(dn) * 20'd3) * 20'd205;
            pct  = 7'd5 + 7'(prod[19:13]);
        end else if (r_v > 15'd3000) begin
            d    = r_v - 15'd3000;
            dn   = d[8:0];
            prod = 20'(dn) * 20'd1093;
            pct  = 7'(prod[19:16]);
        end else begin
            pct = 7'd0;
        end
    end

    assign o_out_push   = (r_state == S_PCT);
    assign o_voltage_mv = r_v;
    assign o_percent    = pct;
    assign o_charging   = ({1'b0, r_v} > ({1'b0, r_prev} + 16'd50));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_prev  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_PCT) begin
                r_prev <= r_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV1 && i_div_rsp.done) begin
            r_mean <= i_div_rsp.quotient[ADC_W-1:0];
        end
        if (r_state == S_MUL1) begin
            r_p1 <= 24'(r_mean) * 24'(K_3300);
        end
        if (r_state == S_MUL2) begin
            r_p2 <= 36'(r_p1) * 36'(i_cfg.ratio);
        end
        if (r_state == S_REC1) begin
            r_q0 <= qsum[28:12];
        end
        if (r_state == S_REC2) begin
            r_rem <= rem_full[12:0];
        end
        if (r_state == S_REC3) begin
            r_v <= (qf > 17'(MV_SAT)) ? MV_SAT : qf[MV_W-1:0];
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> !i_out_full)
        else $error("result pushed into a full queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_rsp.done |-> (r_state == S_DIV1))
        else $error("divide finished outside a divide step");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REC3) |-> (r_rem < 13'd8190))
        else $error("divide by 4095 estimate off by more than one");

endmodule

>>> hw/rtl/battery_fuel_gauge.sv
// battery fuel gauge: moving-average state of charge for a lipo cell
// input queue: drive i_adc_sample with push; a transaction completes when
// push is high and full is low. full rises only when the two-entry work
// queue behind the sample window is taken.
// result queue: o_voltage_mv, o_percent and o_charging hold the oldest result
// while empty is low; a transaction completes when pop is high and empty low.
// the window update is combinational into the work queue; the back end then
// takes each sample through its 16-step divider for sum by count, two multiply
// steps, three steps for the divide by 4095 and the curve step.
// the back end takes a new sample from the work queue only once it is back in
// idle after the last one.
// if pop stays low, results wait in a two-entry output queue; the back end
// holds off while that queue is full and samples keep entering until the
// work queue fills, then full stays high. nothing is dropped.
// configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx at once
// (0 divider ratio q4.8, 1 full mv, 2 empty mv); write only while idle.
// reset (synchronous, active low) empties both queues, clears the window
// and previous voltage and loads the default configuration.
module battery_fuel_gauge #(
    parameter int WINDOW_LEN = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [bfg_pkg::ADC_W-1:0]   i_adc_sample,
    output logic                        empty,
    input  logic                        pop,
    output logic [bfg_pkg::MV_W-1:0]    o_voltage_mv,
    output logic [bfg_pkg::PCT_W-1:0]   o_percent,
    output logic                        o_charging,
    input  logic                        i_cfg_we,
    input  logic [bfg_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [bfg_pkg::CFG_W-1:0]   i_cfg_data
);

    import bfg_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam int WQ_W  = SUM_W + CNT_W;
    localparam int OQ_W  = MV_W + PCT_W + 1;

    t_cfg             r_cfg;
    logic             wq_push, wq_full, wq_pop, wq_empty;
    logic [SUM_W-1:0] wq_sum_in, wq_sum_out;
    logic [CNT_W-1:0] wq_cnt_in, wq_cnt_out;
    logic [WQ_W-1:0]  wq_out;
    t_div_req         div_req;
    t_div_rsp         div_rsp;
    logic             oq_push, oq_full;
    logic [MV_W-1:0]  res_mv;
    logic [PCT_W-1:0] res_pct;
    logic             res_chg;
    logic [OQ_W-1:0]  oq_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ratio    <= RATIO_RST;
            r_cfg.full_mv  <= FULL_MV_RST;
            r_cfg.empty_mv <= EMPTY_MV_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RATIO:    r_cfg.ratio    <= i_cfg_data[RATIO_W-1:0];
                CFG_FULL_MV:  r_cfg.full_mv  <= i_cfg_data[MV_W-1:0];
                CFG_EMPTY_MV: r_cfg.empty_mv <= i_cfg_data[MV_W-1:0];
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    bfg_front #(
        .WINDOW_LEN (WINDOW_LEN),
        .CNT_W      (CNT_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_sample  (i_adc_sample),
        .i_q_full  (wq_full),
        .o_q_push  (wq_push),
        .o_q_sum   (wq_sum_in),
        .o_q_count (wq_cnt_in)
    );

    assign full = wq_full;

    bfg_fifo #(
        .WIDTH (WQ_W),
        .DEPTH (2)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (wq_push),
        .i_data  ({wq_sum_in, wq_cnt_in}),
        .o_full  (wq_full),
        .i_pop   (wq_pop),
        .o_data  (wq_out),
        .o_empty (wq_empty)
    );

    assign wq_sum_out = wq_out[WQ_W-1:CNT_W];
    assign wq_cnt_out = wq_out[CNT_W-1:0];

    bfg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    bfg_back #(
        .CNT_W (CNT_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_empty    (wq_empty),
        .i_q_sum      (wq_sum_out),
        .i_q_count    (wq_cnt_out),
        .o_q_pop      (wq_pop),
        .o_div_req    (div_req),
        .i_div_rsp    (div_rsp),
        .i_out_full   (oq_full),
        .o_out_push   (oq_push),
        .o_voltage_mv (res_mv),
        .o_percent    (res_pct),
        .o_charging   (res_chg)
    );

    bfg_fifo #(
        .WIDTH (OQ_W),
        .DEPTH (2)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (oq_push),
        .i_data  ({res_mv, res_pct, res_chg}),
        .o_full  (oq_full),
        .i_pop   (pop),
        .o_data  (oq_out),
        .o_empty (empty)
    );

    assign o_voltage_mv = oq_out[OQ_W-1:PCT_W+1];
    assign o_percent    = oq_out[PCT_W:1];
    assign o_charging   = oq_out[0];

endmodule
